@@ rtl/core/btpc_pkg.sv @@
`default_nettype none
// Shared types, constants, fixed-point helpers and pipeline stage map for the compensation block.
package btpc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int ADDR_W    = 6;

  // Latencies of the shared arithmetic units.
  localparam int FMUL_LAT = 3;
  localparam int DIV_ITER = 63;
  localparam int DIV_LAT  = DIV_ITER + 2;

  // Pipeline stage map: the register stage at which each value is held, counted in stages from input capture.
  localparam int S_X          = 2 * FMUL_LAT + 2;
  localparam int S_SC         = S_X + 3 * FMUL_LAT + 1;
  localparam int S_Q          = S_SC + 2 + DIV_LAT;
  localparam int S_SUM        = S_Q + 2 * FMUL_LAT + 1;
  localparam int S_PN         = S_SUM + 1;
  localparam int S_OUT        = S_PN + 1;
  localparam int NUM_STAGES   = S_OUT + 1;

  typedef logic signed [63:0] fix_t;

  typedef enum logic [2:0] {
    REG_TEMP_TRIMS  = 3'd0,
    REG_PRESS_ONE   = 3'd1,
    REG_PRESS_2_4   = 3'd2,
    REG_PRESS_5_8   = 3'd3,
    REG_PRESS_NINE  = 3'd4
  } reg_idx_t;

  localparam logic [63:0]        MAG_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam fix_t               FIX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fix_t               FIX_MIN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [64:0] SUM_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN  = -SUM_MAX;
  localparam fix_t FIX_ONE     = fix_t'(64'd1 << FRAC_BITS);
  localparam fix_t FIX_64000   = fix_t'(64'd64000 << FRAC_BITS);
  localparam fix_t FIX_1048576 = fix_t'(64'd1048576 << FRAC_BITS);

  function automatic logic [63:0] fix_mag(input fix_t x);
    logic [63:0] u;
    u = x;
    return u[63] ? (64'd0 - u) : u;
  endfunction

  // Apply sign to a magnitude, saturating at the largest positive magnitude.
  function automatic fix_t fix_from(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    c = (m > MAG_MAX) ? MAG_MAX : m;
    return neg ? fix_t'(64'd0 - c) : fix_t'(c);
  endfunction

  function automatic fix_t fix_clamp(input logic signed [64:0] s);
    fix_t r;
    if (s > SUM_MAX) begin
      r = FIX_MAX;
    end else if (s < SUM_MIN) begin
      r = -FIX_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic fix_t fix_add(input fix_t a, input fix_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return fix_clamp(s);
  endfunction

  function automatic fix_t fix_sub(input fix_t a, input fix_t b);
    fix_t bb;
    logic signed [64:0] s;
    bb = (b == FIX_MIN) ? -FIX_MAX : b;
    s  = 65'(a) - 65'(bb);
    return fix_clamp(s);
  endfunction

  // Shift right with the magnitude truncated toward zero.
  function automatic fix_t fix_shr(input fix_t a, input int k);
    return fix_from(a[63], fix_mag(a) >> k);
  endfunction

  // Product with a small positive integer constant.
  function automatic fix_t fix_mulc(input fix_t a, input logic [15:0] k);
    logic [79:0] p;
    p = 80'(fix_mag(a)) * 80'(k);
    return fix_from(a[63], (|p[79:64]) ? MAG_MAX : p[63:0]);
  endfunction

  // Round to nearest integer of x / 2^(FRAC_BITS+extra), ties away from zero.
  function automatic fix_t fix_round(input fix_t x, input int extra);
    logic [64:0] m;
    m = (65'(fix_mag(x)) + (65'd1 << (FRAC_BITS + extra - 1))) >> (FRAC_BITS + extra);
    return fix_from(x[63], m[63:0]);
  endfunction

  function automatic fix_t fix_s16(input logic [15:0] w);
    fix_t v;
    v = fix_t'(signed'(w));
    return v << FRAC_BITS;
  endfunction

  function automatic fix_t fix_u16(input logic [15:0] w);
    return fix_t'({48'd0, w}) << FRAC_BITS;
  endfunction

  function automatic fix_t fix_u20(input logic [19:0] w);
    return fix_t'({44'd0, w}) << FRAC_BITS;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/btpc_fmul.sv @@
`default_nettype none
// Three-stage saturating fixed-point multiplier built from four 32x32 partial products.
module btpc_fmul (
  input  logic           clk,
  input  logic           en,
  input  btpc_pkg::fix_t a,
  input  btpc_pkg::fix_t b,
  output btpc_pkg::fix_t y
);
  import btpc_pkg::*;

  logic        neg_r, neg2_r;
  logic [63:0] am_r, bm_r;
  logic [63:0] ll_r, lh_r, hl_r, hh_r;
  fix_t        y_r;
  logic [127:0] prod;
  logic [63:0]  mag;

  always_comb begin
    prod = {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {hh_r, 64'd0};
    mag  = (|prod[127:64+FRAC_BITS]) ? MAG_MAX : prod[FRAC_BITS +: 64];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r   <= fix_mag(a);
      bm_r   <= fix_mag(b);
      neg_r  <= a[63] ^ b[63];
      ll_r   <= 64'(am_r[31:0])  * 64'(bm_r[31:0]);
      lh_r   <= 64'(am_r[31:0])  * 64'(bm_r[63:32]);
      hl_r   <= 64'(am_r[63:32]) * 64'(bm_r[31:0]);
      hh_r   <= 64'(am_r[63:32]) * 64'(bm_r[63:32]);
      neg2_r <= neg_r;
      y_r    <= fix_from(neg2_r, mag);
    end
  end

  assign y = y_r;

endmodule
`default_nettype wire

@@ rtl/core/btpc_div.sv @@
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, fixed-point quotient with saturation.
module btpc_div (
  input  logic           clk,
  input  logic           en,
  input  btpc_pkg::fix_t num,
  input  btpc_pkg::fix_t den,
  output btpc_pkg::fix_t quo
);
  import btpc_pkg::*;

  logic [DIV_ITER-1:0] w_r   [DIV_ITER+1];
  logic [63:0]         d_r   [DIV_ITER+1];
  logic [63:0]         r_r   [DIV_ITER+1];
  logic [DIV_ITER-1:0] q_r   [DIV_ITER+1];
  logic                neg_r [DIV_ITER+1];
  logic                ovf_r [DIV_ITER+1];
  logic [63:0]         r_nxt [DIV_ITER];
  logic                b_nxt [DIV_ITER];
  fix_t                quo_r;
  logic [63:0]         nm, dm, top;

  always_comb begin
    nm  = fix_mag(num);
    dm  = fix_mag(den);
    top = nm >> (DIV_ITER - FRAC_BITS);
  end

  always_comb begin
    logic [64:0] sh, df;
    for (int k = 0; k < DIV_ITER; k++) begin
      sh       = {r_r[k], w_r[k][DIV_ITER-1]};
      df       = sh - {1'b0, d_r[k]};
      b_nxt[k] = ~df[64];
      r_nxt[k] = df[64] ? sh[63:0] : df[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0]   <= {nm[DIV_ITER-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      d_r[0]   <= dm;
      r_r[0]   <= top;
      q_r[0]   <= '0;
      neg_r[0] <= num[63] ^ den[63];
      ovf_r[0] <= (top >= dm);
      for (int k = 0; k < DIV_ITER; k++) begin
        w_r[k+1]   <= w_r[k] << 1;
        d_r[k+1]   <= d_r[k];
        r_r[k+1]   <= r_nxt[k];
        q_r[k+1]   <= {q_r[k][DIV_ITER-2:0], b_nxt[k]};
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
      quo_r <= fix_from(neg_r[DIV_ITER],
                        ovf_r[DIV_ITER] ? MAG_MAX : {1'b0, q_r[DIV_ITER]});
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

@@ rtl/core/baro_temp_pressure_compensate.sv @@
`default_nettype none
// Top level of the barometric temperature and pressure compensation pipeline.
//
// One item is a pair of 20-bit raw temperature and pressure readings; one result
// comes back per item: temperature in hundredths of a degree, pressure in pascals
// and a flag set when the pressure scale is zero (pressure then reads 0, as right
// after reset while the trims are still zero). Trims are written over the APB-style
// port at byte address 8*index (temperature trims, pressure trim one, trims two to
// four, trims five to eight, trim nine); write them only while the pipeline is empty.
// The datapath is a 95-stage pipeline that takes an item every cycle unless the
// output is held. Most of that depth is the pressure divider, which resolves
// one quotient bit per stage over 63 stages; the multipliers take three stages each.
// The whole pipeline advances together and holds while a finished result waits at
// the output with out_ready low, so input is taken whenever the output register is
// empty or being drained in the same cycle.
module baro_temp_pressure_compensate (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [19:0]                   in_raw_temperature,
  input  logic [19:0]                   in_raw_pressure,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_temperature_centi,
  output logic [17:0]                   out_pressure_pascal,
  output logic                          out_pressure_invalid
);
  import btpc_pkg::*;

  // ---------------------------------------------------------------- trims
  logic [47:0]        temp_trims_r;
  logic [15:0]        press_trim_one_r;
  logic [47:0]        press_trims_2_4_r;
  logic [63:0]        press_trims_5_8_r;
  logic signed [15:0] press_trim_nine_r;
  logic               cfg_wr;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trims_r      <= '0;
      press_trim_one_r  <= '0;
      press_trims_2_4_r <= '0;
      press_trims_5_8_r <= '0;
      press_trim_nine_r <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TEMP_TRIMS: temp_trims_r      <= pwdata[47:0];
        REG_PRESS_ONE:  press_trim_one_r  <= pwdata[15:0];
        REG_PRESS_2_4:  press_trims_2_4_r <= pwdata[47:0];
        REG_PRESS_5_8:  press_trims_5_8_r <= pwdata;
        REG_PRESS_NINE: press_trim_nine_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TEMP_TRIMS: prdata = {16'd0, temp_trims_r};
      REG_PRESS_ONE:  prdata = {48'd0, press_trim_one_r};
      REG_PRESS_2_4:  prdata = {16'd0, press_trims_2_4_r};
      REG_PRESS_5_8:  prdata = press_trims_5_8_r;
      REG_PRESS_NINE: prdata = {48'd0, press_trim_nine_r};
      default:        prdata = '0;
    endcase
  end

  // Fixed-point trims; user keeps them static while items are in flight, unchecked.
  fix_t t1f, t2f, t3f, p1f, p2f, p3f, p4f, p5f, p6f, p7f, p8f, p9f, p4_sh;
  always_comb begin
    t1f   = fix_u16(temp_trims_r[15:0]);
    t2f   = fix_s16(temp_trims_r[31:16]);
    t3f   = fix_s16(temp_trims_r[47:32]);
    p1f   = fix_u16(press_trim_one_r);
    p2f   = fix_s16(press_trims_2_4_r[15:0]);
    p3f   = fix_s16(press_trims_2_4_r[31:16]);
    p4f   = fix_s16(press_trims_2_4_r[47:32]);
    p5f   = fix_s16(press_trims_5_8_r[15:0]);
    p6f   = fix_s16(press_trims_5_8_r[31:16]);
    p7f   = fix_s16(press_trims_5_8_r[47:32]);
    p8f   = fix_s16(press_trims_5_8_r[63:48]);
    p9f   = fix_s16(press_trim_nine_r);
    // P4 times 65536 is exact: a plain shift of the fixed value.
    p4_sh = p4f << 16;
  end

  // ---------------------------------------------------------------- flow control
  logic [NUM_STAGES-1:0] vld_r;
  logic                  adv;

  // Advance everything at once unless the output holds an untaken result.
  assign adv       = ~vld_r[S_OUT] | out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[S_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- temperature
  logic [19:0] raw_t_r;
  fix_t        adc_t, d1, d2;
  fix_t        m1_y, m2_y, m3_y;
  logic [FMUL_LAT-1:0][63:0] m1_dly_r;
  fix_t        fine_r, tmul_r, x_r;
  fix_t        t_rnd;
  logic signed [15:0] temp_c;
  logic [S_PN-S_X-1:0][15:0] temp_dly_r;

  always_comb begin
    adc_t = fix_u20(raw_t_r);
    d1    = fix_sub(fix_shr(adc_t, 14), fix_shr(t1f, 10));
    d2    = fix_sub(fix_shr(adc_t, 17), fix_shr(t1f, 13));
  end

  btpc_fmul u_m1 (.clk(clk), .en(adv), .a(d1),   .b(t2f), .y(m1_y));
  btpc_fmul u_m2 (.clk(clk), .en(adv), .a(d2),   .b(d2),  .y(m2_y));
  btpc_fmul u_m3 (.clk(clk), .en(adv), .a(m2_y), .b(t3f), .y(m3_y));

  always_comb begin
    t_rnd = fix_round(tmul_r, 8);
    if (t_rnd > 64'sd32767) begin
      temp_c = 16'sh7FFF;
    end else if (t_rnd < -64'sd32768) begin
      temp_c = 16'sh8000;
    end else begin
      temp_c = t_rnd[15:0];
    end
  end

  // ---------------------------------------------------------------- pressure polynomial
  fix_t x_d, m5_y, m6_y, m7_y, m9_y, m10_y, m11_y, m12_y;
  logic [FMUL_LAT-1:0][63:0] x_dly_r, m7_dly_r, m11_dly_r, v2_dly_r;
  fix_t v2a, v2_nxt, w1, u_nxt, v2_r, u_r;

  assign x_d = x_dly_r[FMUL_LAT-1];

  btpc_fmul u_m5  (.clk(clk), .en(adv), .a(x_r),  .b(x_r), .y(m5_y));
  btpc_fmul u_m6  (.clk(clk), .en(adv), .a(m5_y), .b(p6f), .y(m6_y));
  btpc_fmul u_m7  (.clk(clk), .en(adv), .a(x_r),  .b(p5f), .y(m7_y));
  btpc_fmul u_m9  (.clk(clk), .en(adv), .a(p3f),  .b(x_r), .y(m9_y));
  btpc_fmul u_m10 (.clk(clk), .en(adv), .a(m9_y), .b(x_d), .y(m10_y));
  btpc_fmul u_m11 (.clk(clk), .en(adv), .a(p2f),  .b(x_r), .y(m11_y));
  btpc_fmul u_m12 (.clk(clk), .en(adv), .a(u_r),  .b(p1f), .y(m12_y));

  always_comb begin
    v2a    = fix_add(fix_shr(m6_y, 15), fix_mulc(m7_dly_r[FMUL_LAT-1], 16'd2));
    v2_nxt = fix_add(fix_shr(v2a, 2), p4_sh);
    w1     = fix_shr(fix_add(fix_shr(m10_y, 19), m11_dly_r[FMUL_LAT-1]), 19);
    u_nxt  = fix_add(FIX_ONE, fix_shr(w1, 15));
  end

  // ---------------------------------------------------------------- division
  logic [S_SC:0][19:0]        rawp_dly_r;
  logic [S_PN-S_SC-1:0]       bad_dly_r;
  fix_t                       e_r, s_r, num_r, den_r, q_y;
  logic                       scale_zero;

  assign scale_zero = (m12_y == '0);

  btpc_div u_div (.clk(clk), .en(adv), .num(num_r), .den(den_r), .quo(q_y));

  // ---------------------------------------------------------------- quadratic correction
  logic [S_SUM-S_Q-1:0][63:0] q_dly_r;
  logic [FMUL_LAT-1:0][63:0]  m16_dly_r;
  fix_t m14_y, m15_y, m16_y, sum_r, pn_r, p_rnd;
  logic [17:0] pa;

  btpc_fmul u_m14 (.clk(clk), .en(adv), .a(p9f),   .b(q_y), .y(m14_y));
  btpc_fmul u_m15 (.clk(clk), .en(adv), .a(m14_y), .b(q_dly_r[FMUL_LAT-1]), .y(m15_y));
  btpc_fmul u_m16 (.clk(clk), .en(adv), .a(q_y),   .b(p8f), .y(m16_y));

  always_comb begin
    p_rnd = fix_round(pn_r, 0);
    if (bad_dly_r[S_PN-S_SC-1] || p_rnd < 64'sd0) begin
      pa = '0;
    end else if (p_rnd > 64'sd262143) begin
      pa = 18'h3FFFF;
    end else begin
      pa = p_rnd[17:0];
    end
  end

  // ---------------------------------------------------------------- stage registers
  logic signed [15:0] temp_out_r;
  logic [17:0]        press_out_r;
  logic               bad_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_t_r    <= in_raw_temperature;
      rawp_dly_r <= {rawp_dly_r[S_SC-1:0], in_raw_pressure};
      m1_dly_r   <= {m1_dly_r[FMUL_LAT-2:0], m1_y};
      fine_r     <= fix_add(m1_dly_r[FMUL_LAT-1], m3_y);
      tmul_r     <= fix_mulc(fine_r, 16'd5);
      x_r        <= fix_sub(fix_shr(fine_r, 1), FIX_64000);
      temp_dly_r <= {temp_dly_r[S_PN-S_X-2:0], temp_c};
      x_dly_r    <= {x_dly_r[FMUL_LAT-2:0], x_r};
      m7_dly_r   <= {m7_dly_r[FMUL_LAT-2:0], m7_y};
      m11_dly_r  <= {m11_dly_r[FMUL_LAT-2:0], m11_y};
      v2_r       <= v2_nxt;
      u_r        <= u_nxt;
      v2_dly_r   <= {v2_dly_r[FMUL_LAT-2:0], v2_r};
      e_r        <= fix_sub(fix_sub(FIX_1048576, fix_u20(rawp_dly_r[S_SC])),
                            fix_shr(v2_dly_r[FMUL_LAT-1], 12));
      s_r        <= m12_y;
      bad_dly_r  <= {bad_dly_r[S_PN-S_SC-2:0], scale_zero};
      num_r      <= fix_mulc(e_r, 16'd6250);
      den_r      <= s_r;
      q_dly_r    <= {q_dly_r[S_SUM-S_Q-2:0], q_y};
      m16_dly_r  <= {m16_dly_r[FMUL_LAT-2:0], m16_y};
      sum_r      <= fix_add(fix_add(fix_shr(m15_y, 31), fix_shr(m16_dly_r[FMUL_LAT-1], 15)),
                            p7f);
      pn_r       <= fix_add(q_dly_r[S_SUM-S_Q-1], fix_shr(sum_r, 4));
      temp_out_r  <= temp_dly_r[S_PN-S_X-1];
      press_out_r <= pa;
      bad_out_r   <= bad_dly_r[S_PN-S_SC-1];
    end
  end

  assign out_temperature_centi = temp_out_r;
  assign out_pressure_pascal   = press_out_r;
  assign out_pressure_invalid  = bad_out_r;

endmodule
`default_nettype wire
